@@ hdl/stepper_move_by_angle_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the move-by-angle stepper controller
// Shared helpers for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef STEPPER_MOVE_BY_ANGLE_CONTROLLER_ASSERT_SVH
`define STEPPER_MOVE_BY_ANGLE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMBAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smbac: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMBAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smbac: next-cycle check failed");

`endif

@@ hdl/smbac_pkg.sv @@
// ----------------------------------------------------------------------------
// smbac_pkg
// Types, codes and constants shared by the move-by-angle stepper controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smbac_pkg;

    // Field and register widths.
    localparam int BUTTONS_W     = 6;
    localparam int COIL_W        = 4;
    localparam int REMAIN_W      = 16;
    localparam int LOAD_W        = 16;
    localparam int STEP_PERIOD_W = 8;
    localparam int POLL_PERIOD_W = 10;
    localparam int QUARTER_W     = 14;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 14;

    // Phase sequencer.
    localparam int PHASES  = 8;
    localparam int PHASE_W = 3;

    // Mode machine codes.
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROTATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REST   = 2'd2;

    // Direction codes.
    localparam int DIR_W = 2;
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

    // Angle choice codes.
    localparam int ANGLE_W = 2;
    localparam logic [ANGLE_W-1:0] ANGLE_NONE = 2'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_90   = 2'd1;
    localparam logic [ANGLE_W-1:0] ANGLE_180  = 2'd2;
    localparam logic [ANGLE_W-1:0] ANGLE_360  = 2'd3;

    // Button groups.
    localparam logic [BUTTONS_W-1:0] BTN_CW_MASK  = 6'h07;
    localparam logic [BUTTONS_W-1:0] BTN_CCW_MASK = 6'h38;
    localparam logic [BUTTONS_W-1:0] BTN_90_MASK  = 6'h09;
    localparam logic [BUTTONS_W-1:0] BTN_180_MASK = 6'h12;
    localparam logic [BUTTONS_W-1:0] BTN_360_MASK = 6'h24;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_PERIOD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_TURN = 2'd2;

    // Configuration reset values.
    localparam logic [STEP_PERIOD_W-1:0] STEP_PERIOD_RST = 8'd3;
    localparam logic [POLL_PERIOD_W-1:0] POLL_PERIOD_RST = 10'd100;
    localparam logic [QUARTER_W-1:0]     QUARTER_RST     = 14'd1024;

    // Control state carried between the mode machine and the top level.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DIR_W-1:0]   direction;
        logic [ANGLE_W-1:0] angle;
    } ctrl_state_t;

    // Outcome of one phase step.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [COIL_W-1:0]  coil;
        logic               stepped;
    } step_result_t;

    // Half-step coil pattern for each phase index.
    function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

@@ hdl/smbac_divider.sv @@
// ----------------------------------------------------------------------------
// smbac_divider
// Tick divider: fires when the count is zero and wraps at the period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbac_divider #(
    parameter int WIDTH = 8
) (
    input  logic [WIDTH-1:0] count,
    input  logic [WIDTH-1:0] period,
    output logic [WIDTH-1:0] count_next,
    output logic             fire
);

    logic [WIDTH-1:0] eff_period;
    logic [WIDTH:0]   count_inc;

    // A period of zero behaves as a period of one.
    always_comb
    begin
        eff_period = (period == '0) ? WIDTH'(1) : period;
        count_inc  = {1'b0, count} + (WIDTH + 1)'(1);
        fire       = (count == '0);
        if (count_inc >= {1'b0, eff_period})
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_inc[WIDTH-1:0];
        end
    end

endmodule

@@ hdl/smbac_step_engine.sv @@
// ----------------------------------------------------------------------------
// smbac_step_engine
// Half-step phase engine: picks the pattern and moves the phase index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbac_step_engine (
    input  logic                                fire,
    input  logic [smbac_pkg::DIR_W-1:0]         direction,
    input  logic [smbac_pkg::PHASE_W-1:0]       phase,
    input  logic [smbac_pkg::COIL_W-1:0]        coil,
    output smbac_pkg::step_result_t             result
);

    logic [smbac_pkg::COIL_W-1:0] pattern;

    always_comb
    begin
        pattern        = smbac_pkg::half_step_pattern(phase);
        result.phase   = phase;
        result.coil    = coil;
        result.stepped = 1'b0;
        if (fire)
        begin
            // Direction code three behaves as stopped.
            unique case (direction)
                smbac_pkg::DIR_CW:
                begin
                    result.phase   = phase + smbac_pkg::PHASE_W'(1);
                    result.coil    = pattern;
                    result.stepped = 1'b1;
                end
                smbac_pkg::DIR_CCW:
                begin
                    result.phase   = phase - smbac_pkg::PHASE_W'(1);
                    result.coil    = pattern;
                    result.stepped = 1'b1;
                end
                default:
                begin
                    result.phase = '0;
                end
            endcase
        end
    end

endmodule

@@ hdl/smbac_mode_fsm.sv @@
// ----------------------------------------------------------------------------
// smbac_mode_fsm
// Wait, rotate and rest machine that reads the buttons on each poll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbac_mode_fsm #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                fire,
    input  logic [smbac_pkg::BUTTONS_W-1:0]     buttons,
    input  logic [smbac_pkg::QUARTER_W-1:0]     quarter_turn_steps,
    input  smbac_pkg::ctrl_state_t              state_cur,
    input  logic [COUNT_WIDTH-1:0]              count_cur,
    output smbac_pkg::ctrl_state_t              state_new,
    output logic [COUNT_WIDTH-1:0]              count_new
);

    localparam int WIDE = (COUNT_WIDTH > smbac_pkg::LOAD_W) ? COUNT_WIDTH : smbac_pkg::LOAD_W;
    localparam logic [WIDE-1:0] COUNT_MAX = WIDE'({COUNT_WIDTH{1'b1}});

    logic                                cw_pressed;
    logic                                ccw_pressed;
    logic                                any_pressed;
    logic [smbac_pkg::ANGLE_W-1:0]       angle_sel;
    logic [smbac_pkg::LOAD_W-1:0]        quarter_ext;
    logic [smbac_pkg::LOAD_W-1:0]        load_steps;
    logic [WIDE-1:0]                     load_wide;
    logic [WIDE-1:0]                     load_sat;

    // Button decode: clockwise wins, and the smaller angle wins.
    always_comb
    begin
        cw_pressed  = (buttons & smbac_pkg::BTN_CW_MASK) != '0;
        ccw_pressed = (buttons & smbac_pkg::BTN_CCW_MASK) != '0;
        any_pressed = cw_pressed || ccw_pressed;
        if ((buttons & smbac_pkg::BTN_90_MASK) != '0)
        begin
            angle_sel = smbac_pkg::ANGLE_90;
        end
        else if ((buttons & smbac_pkg::BTN_180_MASK) != '0)
        begin
            angle_sel = smbac_pkg::ANGLE_180;
        end
        else if ((buttons & smbac_pkg::BTN_360_MASK) != '0)
        begin
            angle_sel = smbac_pkg::ANGLE_360;
        end
        else
        begin
            angle_sel = state_cur.angle;
        end
    end

    // Step count for the chosen angle, saturated to the counter width.
    always_comb
    begin
        quarter_ext = smbac_pkg::LOAD_W'(quarter_turn_steps);
        case (angle_sel)
            smbac_pkg::ANGLE_90:  load_steps = quarter_ext;
            smbac_pkg::ANGLE_180: load_steps = quarter_ext << 1;
            smbac_pkg::ANGLE_360: load_steps = quarter_ext << 2;
            default:              load_steps = '0;
        endcase
        load_wide = WIDE'(load_steps);
        load_sat  = (load_wide > COUNT_MAX) ? COUNT_MAX : load_wide;
    end

    // Mode transitions, taken only on a poll tick.
    always_comb
    begin
        state_new = state_cur;
        count_new = count_cur;
        if (fire)
        begin
            unique case (state_cur.mode)
                smbac_pkg::MODE_WAIT:
                begin
                    state_new.direction = cw_pressed  ? smbac_pkg::DIR_CW  :
                                          ccw_pressed ? smbac_pkg::DIR_CCW :
                                                        smbac_pkg::DIR_STOP;
                    state_new.angle     = angle_sel;
                    count_new           = load_sat[COUNT_WIDTH-1:0];
                    if (any_pressed)
                    begin
                        state_new.mode = smbac_pkg::MODE_ROTATE;
                    end
                end
                smbac_pkg::MODE_ROTATE:
                begin
                    if (count_cur == '0)
                    begin
                        state_new.mode = smbac_pkg::MODE_REST;
                    end
                end
                smbac_pkg::MODE_REST:
                begin
                    state_new.direction = smbac_pkg::DIR_STOP;
                    if (!any_pressed)
                    begin
                        state_new.mode = smbac_pkg::MODE_WAIT;
                    end
                end
                default:
                begin
                    state_new = state_cur;
                end
            endcase
        end
    end

endmodule

@@ hdl/stepper_move_by_angle_controller.sv @@
// ----------------------------------------------------------------------------
// stepper_move_by_angle_controller
// Half-step stepper sequencer with a move-by-angle button front end.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction (in_valid high, in_stall low) is one scheduler tick
// carrying the six button lines. Every tick produces exactly one output
// transaction with the coil pattern, the remaining step count, the mode and
// the stepped flag, presented on out_valid until accepted with out_stall low.
// The result of a tick is shown in the cycle after it is accepted. Throughput
// is one tick per cycle while the receiver does not stall; the whole tick
// (two dividers, the phase engine and the mode machine) is evaluated in one
// pass between the state registers and the result register.
// When the receiver stalls with a result waiting, in_stall rises and no tick
// is taken until the result leaves; a tick is taken in the same cycle as the
// waiting result is accepted.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the block is idle.
// Reset clears the mode machine, counters and coils, and loads the default
// periods (3 and 100 ticks) and a quarter turn of 1024 steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_move_by_angle_controller #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Tick input channel.
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [smbac_pkg::BUTTONS_W-1:0]         buttons,
    // Result channel.
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [smbac_pkg::COIL_W-1:0]            coil_pattern,
    output logic [smbac_pkg::REMAIN_W-1:0]          remaining_steps,
    output logic [smbac_pkg::MODE_W-1:0]            mode,
    output logic                                    stepped,
    // Configuration write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [smbac_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [smbac_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int WIDE = (COUNT_WIDTH > smbac_pkg::REMAIN_W) ? COUNT_WIDTH : smbac_pkg::REMAIN_W;

    // Configuration registers.
    logic [smbac_pkg::STEP_PERIOD_W-1:0]    step_period_reg;
    logic [smbac_pkg::POLL_PERIOD_W-1:0]    poll_period_reg;
    logic [smbac_pkg::QUARTER_W-1:0]        quarter_turn_reg;

    // Tick state.
    smbac_pkg::ctrl_state_t                 ctrl_reg;
    smbac_pkg::ctrl_state_t                 ctrl_next;
    logic [smbac_pkg::PHASE_W-1:0]          phase_reg;
    logic [smbac_pkg::COIL_W-1:0]           coil_reg;
    logic [COUNT_WIDTH-1:0]                 count_reg;
    logic [COUNT_WIDTH-1:0]                 count_next;
    logic [smbac_pkg::STEP_PERIOD_W-1:0]    step_div_reg;
    logic [smbac_pkg::STEP_PERIOD_W-1:0]    step_div_next;
    logic [smbac_pkg::POLL_PERIOD_W-1:0]    poll_div_reg;
    logic [smbac_pkg::POLL_PERIOD_W-1:0]    poll_div_next;

    // Result register.
    logic                                   out_valid_reg;
    logic [smbac_pkg::COIL_W-1:0]           coil_out_reg;
    logic [smbac_pkg::REMAIN_W-1:0]         remain_out_reg;
    logic [smbac_pkg::MODE_W-1:0]           mode_out_reg;
    logic                                   stepped_out_reg;

    logic                                   in_accept;
    logic                                   out_accept;
    logic                                   step_fire;
    logic                                   poll_fire;
    smbac_pkg::step_result_t                step_res;
    logic [COUNT_WIDTH-1:0]                 count_after_step;
    logic [WIDE-1:0]                        count_wide;

    // Handshakes: a tick is taken whenever the result register is free or leaving.
    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;

    // Tick dividers for the phase engine and the button poll.
    smbac_divider #(
        .WIDTH (smbac_pkg::STEP_PERIOD_W)
    ) u_step_div (
        .count      (step_div_reg),
        .period     (step_period_reg),
        .count_next (step_div_next),
        .fire       (step_fire)
    );

    smbac_divider #(
        .WIDTH (smbac_pkg::POLL_PERIOD_W)
    ) u_poll_div (
        .count      (poll_div_reg),
        .period     (poll_period_reg),
        .count_next (poll_div_next),
        .fire       (poll_fire)
    );

    // Phase step runs first, on the direction held before the poll.
    smbac_step_engine u_step (
        .fire      (step_fire),
        .direction (ctrl_reg.direction),
        .phase     (phase_reg),
        .coil      (coil_reg),
        .result    (step_res)
    );

    // The step count only counts down while above zero.
    assign count_after_step = (step_res.stepped && (count_reg != '0)) ?
                              count_reg - COUNT_WIDTH'(1) : count_reg;

    // The poll sees the count left by the step of the same tick.
    smbac_mode_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mode (
        .fire               (poll_fire),
        .buttons            (buttons),
        .quarter_turn_steps (quarter_turn_reg),
        .state_cur          (ctrl_reg),
        .count_cur          (count_after_step),
        .state_new          (ctrl_next),
        .count_new          (count_next)
    );

    // Low sixteen bits of the counter for the result.
    assign count_wide = WIDE'(count_next);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg  <= smbac_pkg::STEP_PERIOD_RST;
            poll_period_reg  <= smbac_pkg::POLL_PERIOD_RST;
            quarter_turn_reg <= smbac_pkg::QUARTER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                smbac_pkg::REG_STEP_PERIOD:
                    step_period_reg <= cfg_data[smbac_pkg::STEP_PERIOD_W-1:0];
                smbac_pkg::REG_POLL_PERIOD:
                    poll_period_reg <= cfg_data[smbac_pkg::POLL_PERIOD_W-1:0];
                smbac_pkg::REG_QUARTER_TURN:
                    quarter_turn_reg <= cfg_data[smbac_pkg::QUARTER_W-1:0];
                default:
                begin
                    step_period_reg <= step_period_reg;
                end
            endcase
        end
    end

    // Tick state update on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.mode      <= smbac_pkg::MODE_WAIT;
            ctrl_reg.direction <= smbac_pkg::DIR_STOP;
            ctrl_reg.angle     <= smbac_pkg::ANGLE_NONE;
            phase_reg          <= '0;
            coil_reg           <= '0;
            count_reg          <= '0;
            step_div_reg       <= '0;
            poll_div_reg       <= '0;
        end
        else if (in_accept)
        begin
            ctrl_reg     <= ctrl_next;
            phase_reg    <= step_res.phase;
            coil_reg     <= step_res.coil;
            count_reg    <= count_next;
            step_div_reg <= step_div_next;
            poll_div_reg <= poll_div_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each tick.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            coil_out_reg    <= step_res.coil;
            remain_out_reg  <= count_wide[smbac_pkg::REMAIN_W-1:0];
            mode_out_reg    <= ctrl_next.mode;
            stepped_out_reg <= step_res.stepped;
        end
    end

    assign out_valid       = out_valid_reg;
    assign coil_pattern    = coil_out_reg;
    assign remaining_steps = remain_out_reg;
    assign mode            = mode_out_reg;
    assign stepped         = stepped_out_reg;

endmodule

@@ hdl/smbac_checker.sv @@
// ----------------------------------------------------------------------------
// smbac_checker
// Port-level checks for the move-by-angle stepper controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stepper_move_by_angle_controller_assert.svh"

module smbac_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [smbac_pkg::COIL_W-1:0]        coil_pattern,
    input  logic                                stepped
);

    // Every accepted tick yields a result in the next cycle.
    `SMBAC_ASSERT_NEXT(a_tick_gives_result, clk, rst_n, in_valid && !in_stall, out_valid)

    // Ticks are held off only while a result is waiting on a stalled receiver.
    `SMBAC_ASSERT_NOW(a_stall_back, clk, rst_n, in_stall, out_valid && out_stall)

    // A stepped tick always drives a non-empty half-step pattern.
    `SMBAC_ASSERT_NOW(a_step_drives_coils, clk, rst_n, out_valid && stepped, coil_pattern != '0)

    // A stalled result stays on the port.
    `SMBAC_ASSERT_NEXT(a_stalled_result_holds, clk, rst_n, out_valid && out_stall,
                       out_valid && $stable(coil_pattern) && $stable(stepped))

endmodule

bind stepper_move_by_angle_controller smbac_checker u_smbac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coil_pattern (coil_pattern),
    .stepped      (stepped)
);

@@ tb/sv/stepper_move_by_angle_controller_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the move-by-angle stepper controller
// Drives scheduler ticks with button patterns and keeps its own model of the
// step and poll dividers, the half-step phase engine and the wait, rotate and
// rest machine. Every result transaction is compared field by field with the
// model's prediction. The run covers the reset defaults, the button
// priorities, zero and full-scale register settings, a long receiver
// hold-off and random moves with idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_move_by_angle_controller_tb;

    localparam int          COUNT_WIDTH   = 16;
    localparam int unsigned COUNT_MAX     = (1 << COUNT_WIDTH) - 1;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          MOVE_PHASES   = 6;
    localparam int          PHASE_TICKS   = 70;

    // Index that decodes to no register; a write there must change nothing.
    localparam logic [smbac_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // Half-step coil patterns, phase 0 in the lowest nibble.
    localparam logic [smbac_pkg::PHASES*smbac_pkg::COIL_W-1:0] HALF_STEP_SEQ = 32'h98C4_6231;

    typedef struct packed {
        logic [smbac_pkg::COIL_W-1:0]   coil;
        logic [smbac_pkg::REMAIN_W-1:0] remaining;
        logic [smbac_pkg::MODE_W-1:0]   mode;
        logic                           stepped;
    } tick_result_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic [smbac_pkg::BUTTONS_W-1:0]   buttons   = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [smbac_pkg::COIL_W-1:0]      coil_pattern;
    logic [smbac_pkg::REMAIN_W-1:0]    remaining_steps;
    logic [smbac_pkg::MODE_W-1:0]      mode;
    logic                              stepped;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [smbac_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [smbac_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register copies, at their reset values.
    logic [smbac_pkg::STEP_PERIOD_W-1:0] step_period_reg  = smbac_pkg::STEP_PERIOD_RST;
    logic [smbac_pkg::POLL_PERIOD_W-1:0] poll_period_reg  = smbac_pkg::POLL_PERIOD_RST;
    logic [smbac_pkg::QUARTER_W-1:0]     quarter_turn_reg = smbac_pkg::QUARTER_RST;

    // Sequencer state, as after reset.
    logic [smbac_pkg::MODE_W-1:0]        seq_mode     = smbac_pkg::MODE_WAIT;
    logic [smbac_pkg::DIR_W-1:0]         seq_dir      = smbac_pkg::DIR_STOP;
    logic [smbac_pkg::PHASE_W-1:0]       seq_phase    = '0;
    logic [COUNT_WIDTH-1:0]              seq_count    = '0;
    logic [smbac_pkg::ANGLE_W-1:0]       seq_angle    = smbac_pkg::ANGLE_NONE;
    logic [smbac_pkg::STEP_PERIOD_W-1:0] seq_step_div = '0;
    logic [smbac_pkg::POLL_PERIOD_W-1:0] seq_poll_div = '0;
    logic [smbac_pkg::COIL_W-1:0]        seq_coil     = '0;

    tick_result_t tick_results_due[$];

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    int hold_request = 0;

    int cycle_count     = 0;
    int mismatch_count  = 0;
    int ticks_sent      = 0;
    int results_checked = 0;
    int register_writes = 0;
    int settings_used   = 0;
    int long_holds      = 0;
    int moves_cw        = 0;
    int moves_ccw       = 0;

    stepper_move_by_angle_controller #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .buttons         (buttons),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .coil_pattern    (coil_pattern),
        .remaining_steps (remaining_steps),
        .mode            (mode),
        .stepped         (stepped),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    // Safety net against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, tick_results_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Gap lengths: mostly short, now and then a long one.
    function automatic int unsigned pick_gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return $urandom_range(1, 3);
        else if (roll < 93)
            return $urandom_range(4, 9);
        else
            return $urandom_range(15, 40);
    endfunction

    // Random button pattern within the given range.
    function automatic logic [smbac_pkg::BUTTONS_W-1:0] random_buttons(input int unsigned lo);
        return smbac_pkg::BUTTONS_W'($urandom_range(lo, 63));
    endfunction

    // Advances the sequencer by one tick and returns the result it shows.
    function automatic tick_result_t advance_sequencer(
        input logic [smbac_pkg::BUTTONS_W-1:0] b);
        tick_result_t                 r;
        logic [smbac_pkg::COIL_W-1:0] pattern;
        logic                         cw_pressed;
        logic                         ccw_pressed;
        int unsigned                  period;
        int unsigned                  load;
        r.stepped = 1'b0;

        // Phase engine; it runs before the poll when both fall on one tick.
        period = (step_period_reg == 0) ? 1 : step_period_reg;
        if (seq_step_div == 0)
        begin
            pattern = HALF_STEP_SEQ[seq_phase*smbac_pkg::COIL_W +: smbac_pkg::COIL_W];
            if (seq_dir == smbac_pkg::DIR_CW)
                seq_phase = seq_phase + 3'd1;
            else if (seq_dir == smbac_pkg::DIR_CCW)
                seq_phase = seq_phase - 3'd1;
            else
                seq_phase = '0;
            if (seq_dir == smbac_pkg::DIR_CW || seq_dir == smbac_pkg::DIR_CCW)
            begin
                seq_coil = pattern;
                if (seq_count != 0)
                    seq_count = seq_count - 1'b1;
                r.stepped = 1'b1;
            end
        end
        if (seq_step_div + 32'd1 >= period)
            seq_step_div = '0;
        else
            seq_step_div = seq_step_div + 1'b1;

        // Button poll of the wait, rotate and rest machine.
        period = (poll_period_reg == 0) ? 1 : poll_period_reg;
        if (seq_poll_div == 0)
        begin
            cw_pressed  = (b & smbac_pkg::BTN_CW_MASK) != 0;
            ccw_pressed = (b & smbac_pkg::BTN_CCW_MASK) != 0;
            case (seq_mode)
                smbac_pkg::MODE_WAIT:
                begin
                    seq_dir = cw_pressed  ? smbac_pkg::DIR_CW :
                              ccw_pressed ? smbac_pkg::DIR_CCW : smbac_pkg::DIR_STOP;
                    if ((b & smbac_pkg::BTN_90_MASK) != 0)
                        seq_angle = smbac_pkg::ANGLE_90;
                    else if ((b & smbac_pkg::BTN_180_MASK) != 0)
                        seq_angle = smbac_pkg::ANGLE_180;
                    else if ((b & smbac_pkg::BTN_360_MASK) != 0)
                        seq_angle = smbac_pkg::ANGLE_360;
                    case (seq_angle)
                        smbac_pkg::ANGLE_90:  load = quarter_turn_reg;
                        smbac_pkg::ANGLE_180: load = quarter_turn_reg * 2;
                        smbac_pkg::ANGLE_360: load = quarter_turn_reg * 4;
                        default:              load = 0;
                    endcase
                    seq_count = COUNT_WIDTH'((load > COUNT_MAX) ? COUNT_MAX : load);
                    if (cw_pressed)
                        moves_cw++;
                    else if (ccw_pressed)
                        moves_ccw++;
                    if (cw_pressed || ccw_pressed)
                        seq_mode = smbac_pkg::MODE_ROTATE;
                end
                smbac_pkg::MODE_ROTATE:
                begin
                    if (seq_count == 0)
                        seq_mode = smbac_pkg::MODE_REST;
                end
                smbac_pkg::MODE_REST:
                begin
                    seq_dir = smbac_pkg::DIR_STOP;
                    if (!(cw_pressed || ccw_pressed))
                        seq_mode = smbac_pkg::MODE_WAIT;
                end
                default: ;
            endcase
        end
        if (seq_poll_div + 32'd1 >= period)
            seq_poll_div = '0;
        else
            seq_poll_div = seq_poll_div + 1'b1;

        r.coil      = seq_coil;
        r.remaining = seq_count[smbac_pkg::REMAIN_W-1:0];
        r.mode      = seq_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Offers one tick, after a random gap when idling is on, and records the
    // result that it must produce.
    task automatic send_tick(input logic [smbac_pkg::BUTTONS_W-1:0] b);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 1) == 0)
        begin
            gap = pick_gap_length();
            in_valid <= 1'b0;
            buttons  <= random_buttons(0);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        buttons  <= b;
        do @(posedge clk); while (in_stall);
        tick_results_due.push_back(advance_sequencer(b));
        ticks_sent++;
    endtask

    // Stops offering ticks and waits until every result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tick_results_due.size() != 0)
            @(posedge clk);
    endtask

    // One configuration transaction; cfg_valid is left high for the caller.
    task automatic write_register(input logic [smbac_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [smbac_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            smbac_pkg::REG_STEP_PERIOD:
                step_period_reg  = data[smbac_pkg::STEP_PERIOD_W-1:0];
            smbac_pkg::REG_POLL_PERIOD:
                poll_period_reg  = data[smbac_pkg::POLL_PERIOD_W-1:0];
            smbac_pkg::REG_QUARTER_TURN:
                quarter_turn_reg = data[smbac_pkg::QUARTER_W-1:0];
            default: ;
        endcase
        register_writes++;
    endtask

    task automatic configure(input logic [smbac_pkg::CFG_DATA_W-1:0] step_data,
                             input logic [smbac_pkg::CFG_DATA_W-1:0] poll_data,
                             input logic [smbac_pkg::CFG_DATA_W-1:0] quarter_data,
                             input bit spare_write);
        write_register(smbac_pkg::REG_STEP_PERIOD, step_data);
        write_register(smbac_pkg::REG_POLL_PERIOD, poll_data);
        write_register(smbac_pkg::REG_QUARTER_TURN, quarter_data);
        if (spare_write)
            write_register(REG_SPARE, 14'h2AAA);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Releases the buttons, with occasional stray presses when noisy, until
    // the machine is back in wait.
    task automatic return_to_wait(input bit noisy);
        while (seq_mode != smbac_pkg::MODE_WAIT)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_tick(random_buttons(1));
            else
                send_tick('0);
        end
    endtask

    // Reset defaults: the first tick polls, later presses fall between polls.
    task automatic test_reset_defaults();
        send_tick('0);
        repeat (5) send_tick(random_buttons(1));
        drain_results();
    endtask

    // Clockwise beats counter-clockwise, and the smaller angle wins.
    task automatic test_button_priority();
        configure(14'd1, 14'd1, 14'd1, 1'b1);
        send_tick(6'h3F);
        return_to_wait(1'b0);
        send_tick(6'h36);
        return_to_wait(1'b0);
        send_tick(6'h20);
        return_to_wait(1'b0);
        // No button in wait reloads the count from the last chosen angle.
        send_tick('0);
        drain_results();
    endtask

    // Full-scale and zero periods, a period cut below its divider, and
    // register data with bits above the register width.
    task automatic test_register_extremes();
        configure(14'd255, 14'd1023, 14'd16383, 1'b0);
        repeat (3) send_tick('0);
        drain_results();
        configure(14'd0, 14'd0, 14'd0, 1'b0);
        repeat (3) send_tick('0);
        drain_results();
        configure(14'h3F02, 14'h3C03, 14'd3, 1'b1);
        repeat (2) send_tick('0);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, so
    // the block fills up and stalls its input.
    task automatic test_input_backpressure();
        tx_idle_on   = 1'b0;
        hold_request = 120;
        send_tick(6'h08);
        repeat (14) send_tick($urandom_range(0, 1) ? 6'h00 : 6'h08);
        tx_idle_on = 1'b1;
        return_to_wait(1'b0);
        drain_results();
    endtask

    // Random settings, mostly well-formed moves with random buttons, some
    // noise in between.
    task automatic test_random_moves();
        int                               start;
        int unsigned                      held;
        logic [smbac_pkg::BUTTONS_W-1:0]  press;
        logic [smbac_pkg::CFG_DATA_W-1:0] sp;
        logic [smbac_pkg::CFG_DATA_W-1:0] pp;
        logic [smbac_pkg::CFG_DATA_W-1:0] qt;
        for (int ph = 0; ph < MOVE_PHASES; ph++)
        begin
            if (ph == MOVE_PHASES - 1)
            begin
                sp = smbac_pkg::CFG_DATA_W'($urandom_range(5, 8));
                qt = smbac_pkg::CFG_DATA_W'($urandom_range(1, 3));
            end
            else
            begin
                sp = smbac_pkg::CFG_DATA_W'($urandom_range(1, 4));
                qt = smbac_pkg::CFG_DATA_W'($urandom_range(1, 5));
            end
            pp = smbac_pkg::CFG_DATA_W'($urandom_range(1, 6));
            configure(sp, pp, qt, ph == 0);
            // Stretches with no idling on one side or the other.
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 3);
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    press = random_buttons(1);
                    held  = $urandom_range(1, pp);
                    repeat (held) send_tick(press);
                    return_to_wait(1'b1);
                end
                else
                begin
                    repeat ($urandom_range(1, 6)) send_tick(random_buttons(0));
                end
            end
            drain_results();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver: random stalls, and a long counted hold-off when asked.
    initial
    begin
        int n;
        forever
        begin
            if (hold_request != 0)
            begin
                n = hold_request;
                hold_request = 0;
                long_holds++;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (pick_gap_length()) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // Each result transaction against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (tick_results_due.size() == 0)
                report_mismatch("result with no tick outstanding", 1, 0);
            else
            begin
                want = tick_results_due.pop_front();
                if (coil_pattern !== want.coil)
                    report_mismatch("coil_pattern", 32'(coil_pattern), 32'(want.coil));
                if (remaining_steps !== want.remaining)
                    report_mismatch("remaining_steps", 32'(remaining_steps),
                                    32'(want.remaining));
                if (mode !== want.mode)
                    report_mismatch("mode", 32'(mode), 32'(want.mode));
                if (stepped !== want.stepped)
                    report_mismatch("stepped", 32'(stepped), 32'(want.stepped));
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_button_priority();
        test_register_extremes();
        test_input_backpressure();
        test_random_moves();

        // Let any stray result show up before the verdict.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d ticks and checked %0d results over %0d register settings (%0d writes).",
                 ticks_sent, results_checked, settings_used, register_writes);
        $display("Started %0d clockwise and %0d counter-clockwise moves; %0d long hold-off(s).",
                 moves_cw, moves_ccw, long_holds);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
